// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while in reset
`define BDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion, also checked in reset
`define BDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: rtl/bdc_pkg.sv
`default_nettype none

package bdc_pkg;

  localparam int unsigned BAUD_W        = 24;
  localparam int unsigned REF_W         = 28;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned FRAC_BITS     = 32;
  localparam int unsigned RATE_SHIFT    = 4;
  localparam int unsigned DIVIDEND_BITS = 64;
  localparam int unsigned BAUD_LSB_POS  = FRAC_BITS + RATE_SHIFT;
  localparam int unsigned BAUD_END_POS  = BAUD_LSB_POS + BAUD_W;

  localparam logic [REF_W-1:0] REF_CLOCK_RESET = REF_W'(16000000);

  typedef struct packed {
    logic [BAUD_W-1:0]    baud;
    logic [REF_W-1:0]     rem;
    logic                 sticky;   // any quotient bit at or above 2^33
    logic                 q32;
    logic [FRAC_BITS-1:0] qlo;
  } div_stage_t;

  function automatic logic dividend_bit(input logic [BAUD_W-1:0] baud,
                                        input int unsigned pos);
    logic [4:0] idx;
    idx = 5'(pos - BAUD_LSB_POS);
    if (pos >= BAUD_LSB_POS && pos < BAUD_END_POS) begin
      return baud[idx];
    end
    return 1'b0;
  endfunction

  // one restoring step for quotient bit pos
  function automatic div_stage_t div_step(input div_stage_t prev,
                                          input logic [REF_W-1:0] den,
                                          input int unsigned pos);
    div_stage_t   nxt;
    logic [REF_W:0] trial;
    logic         qb;
    nxt   = prev;
    trial = {prev.rem, dividend_bit(prev.baud, pos)};
    qb    = (trial >= {1'b0, den});
    nxt.rem = qb ? REF_W'(trial - {1'b0, den}) : trial[REF_W-1:0];
    if (pos > FRAC_BITS) begin
      nxt.sticky = prev.sticky | qb;
    end else if (pos == FRAC_BITS) begin
      nxt.q32 = qb;
    end else begin
      nxt.qlo[pos[4:0]] = qb;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bdc_in_if.sv
`default_nettype none

interface bdc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bdc_pkg::BAUD_W-1:0]  baud_rate;

  modport source (output valid, output baud_rate, input ready);
  modport sink   (input valid, input baud_rate, output ready);
endinterface

`default_nettype wire

// File: rtl/bdc_out_if.sv
`default_nettype none

interface bdc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bdc_pkg::VALUE_W-1:0] baud_value;
  logic                        out_of_range;

  modport source (output valid, output baud_value, output out_of_range, input ready);
  modport sink   (input valid, input baud_value, input out_of_range, output ready);
endinterface

`default_nettype wire

// File: rtl/baud_divisor_calculator.sv
// Baud divisor calculator: for each baud_rate word it returns the 16-bit
// arithmetic-mode baud value 65536*(1 - 16*baud_rate/ref_clock_hz). The ratio
// comes from a restoring divider pipelined one quotient bit per stage, so a
// new word is accepted every cycle while the output is not stalled. A word
// loads the first divider stage at its accepting edge, then passes through
// DIVIDEND_BITS - 1 more divider stages and one output stage. A stalled output
// holds the filled stages. Rates above ref_clock_hz/16, a zero reference
// clock and a zero ratio are flagged with out_of_range, and the value
// saturates to 0 or 65535. Write cfg_wr_data only while no word is in flight.
`default_nettype none
`include "assert_macros.svh"

module baud_divisor_calculator #(
  parameter int unsigned DIVIDEND_BITS = bdc_pkg::DIVIDEND_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  bdc_in_if.sink                         in_ch,
  bdc_out_if.source                      out_ch,
  input  wire logic                      cfg_wr_en,
  input  wire logic [bdc_pkg::REF_W-1:0] cfg_wr_data
);

  localparam int unsigned N = DIVIDEND_BITS;

  logic [bdc_pkg::REF_W-1:0] ref_clock_r;

  logic                 v_r   [N];
  bdc_pkg::div_stage_t  st_r  [N];
  bdc_pkg::div_stage_t  st_nxt[N];
  logic [N:0]           rdy;

  logic                          out_v_r;
  logic [bdc_pkg::VALUE_W-1:0]   value_r;
  logic                          flag_r;
  logic [bdc_pkg::VALUE_W-1:0]   value_nxt;
  logic                          flag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_clock_r <= bdc_pkg::REF_CLOCK_RESET;
    end else if (cfg_wr_en) begin
      ref_clock_r <= cfg_wr_data;
    end
  end

  assign rdy[N]      = out_ch.ready || !out_v_r;
  assign in_ch.ready = rdy[0];

  genvar s;
  generate
    for (s = 0; s < N; s++) begin : g_stage
      localparam int unsigned POS = N - 1 - s;

      assign rdy[s] = !v_r[s] || rdy[s+1];

      if (s == 0) begin : g_first
        bdc_pkg::div_stage_t seed;
        always_comb begin
          seed        = '0;
          seed.baud   = in_ch.baud_rate;
          st_nxt[s]   = bdc_pkg::div_step(seed, ref_clock_r, POS);
        end
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[s] <= 1'b0;
          end else if (rdy[s]) begin
            v_r[s] <= in_ch.valid;
          end
        end
      end else begin : g_next
        always_comb begin
          st_nxt[s] = bdc_pkg::div_step(st_r[s-1], ref_clock_r, POS);
        end
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[s] <= 1'b0;
          end else if (rdy[s]) begin
            v_r[s] <= v_r[s-1];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          st_r[s] <= st_nxt[s];
        end
      end
    end
  endgenerate

  // final mapping of the 2^-32 fixed-point ratio
  always_comb begin
    logic [bdc_pkg::FRAC_BITS:0] diff;
    diff = {1'b1, {bdc_pkg::FRAC_BITS{1'b0}}} - {1'b0, st_r[N-1].qlo};
    if (st_r[N-1].sticky || (st_r[N-1].q32 && (st_r[N-1].qlo != '0))) begin
      value_nxt = '0;
      flag_nxt  = 1'b1;
    end else if (st_r[N-1].q32) begin
      value_nxt = '0;
      flag_nxt  = 1'b0;
    end else if (st_r[N-1].qlo == '0) begin
      value_nxt = '1;
      flag_nxt  = 1'b1;
    end else begin
      value_nxt = diff[bdc_pkg::FRAC_BITS-1 -: bdc_pkg::VALUE_W];
      flag_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy[N]) begin
      out_v_r <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[N]) begin
      value_r <= value_nxt;
      flag_r  <= flag_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.baud_value   = value_r;
  assign out_ch.out_of_range = flag_r;

  `BDC_ASSERT(a_flag_saturates, out_ch.valid && out_ch.out_of_range |-> (out_ch.baud_value == '0 || out_ch.baud_value == '1), "flagged word not saturated")
  `BDC_ASSERT(a_accept_enters, in_ch.valid && in_ch.ready |=> v_r[0], "accepted word did not enter the pipeline")
  `BDC_ASSERT(a_stall_holds, out_ch.valid && !out_ch.ready && v_r[N-1] |=> v_r[N-1] && out_ch.valid, "word lost during output stall")

endmodule

`default_nettype wire
